/* hw/rtl/vrt_pkg.sv */
// Package for the virtual region table: operation, status and kind codes,
// sequencer states and default geometry. No dependencies.
`default_nettype none
package vrt_pkg;
    localparam int DefTableDepth = 32;
    localparam int DefPageShift  = 12;
    localparam int DefVaBits     = 39;
    localparam logic [38:0] MappingBaseReset = 39'h0010000000;

    typedef enum logic [2:0] {
        OP_MAP    = 3'd0,
        OP_UNMAP  = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_SPACE  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_MISALIGN = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_NOTSTART = 3'd5,
        ST_TOOLONG  = 3'd6,
        ST_FILE_RO  = 3'd7
    } t_status;

    localparam logic [2:0] KindStack = 3'd1;
    localparam logic [2:0] KindFile  = 3'd3;
    localparam logic [2:0] KindAnon  = 3'd4;
    localparam int PermWrite  = 1;
    localparam int PermShared = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

/* hw/rtl/virtual_region_table_unit.sv */
// Virtual region table: one sequencer scans the table entry by entry with a
// shared compare unit. Depends on vrt_pkg.
//
// Each request runs through S_SCAN, which reads one table entry per cycle
// through the single read port, then through S_DECIDE and S_OUT.
// Requests are taken one at a time, only in S_IDLE: a new request waits until
// the result has been accepted, also while the output is stalled.
// Reset: synchronous, active low; empties the table (valid bits only) and
// loads mapping_base with 0x10000000. No clearing pass is needed.
`default_nettype none
module virtual_region_table_unit #(
    parameter int TABLE_DEPTH = vrt_pkg::DefTableDepth,
    parameter int PAGE_SHIFT  = vrt_pkg::DefPageShift,
    parameter int VA_BITS     = vrt_pkg::DefVaBits
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [VA_BITS-1:0] i_cfg_wdata,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // operation[2:0], address, length, perm[3:0], region_type[2:0],
    // file_writable, zero fill to bytes
    input  wire logic [((3+2*VA_BITS+8)+7)/8*8-1:0] i_s_tdata,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // status[2:0], found_start, found_size, found_perm[3:0], found_type[2:0],
    // writeback_needed, close_file, release_start, release_pages,
    // space_address, zero fill to bytes
    output logic [((3+4*VA_BITS+9+VA_BITS-PAGE_SHIFT+1)+7)/8*8-1:0]
                      o_m_tdata
);
    import vrt_pkg::*;

    localparam int PB  = VA_BITS - PAGE_SHIFT;      // page number width
    localparam int CB  = PB + 1;                    // page count width
    localparam int IB  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDW = ((3+2*VA_BITS+8)+7)/8*8;
    localparam int ODW = ((3+4*VA_BITS+9+CB)+7)/8*8;
    localparam int ODF = 3+4*VA_BITS+9+CB;
    localparam int IDF = 3+2*VA_BITS+8;
    localparam logic [IB:0] LastIdx = (IB+1)'(TABLE_DEPTH - 1);

    // Unpack request
    logic [2:0] in_op, in_kind;
    logic [VA_BITS-1:0] in_addr, in_len;
    logic [3:0] in_perm;
    logic in_fw;
    assign in_op   = i_s_tdata[2:0];
    assign in_addr = i_s_tdata[3 +: VA_BITS];
    assign in_len  = i_s_tdata[3+VA_BITS +: VA_BITS];
    assign in_perm = i_s_tdata[3+2*VA_BITS +: 4];
    assign in_kind = i_s_tdata[7+2*VA_BITS +: 3];
    assign in_fw   = i_s_tdata[10+2*VA_BITS];

    // Table storage: valid bits in flops, fields in a memory
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [PB-1:0] mem_start [TABLE_DEPTH];
    logic [CB-1:0] mem_count [TABLE_DEPTH];
    logic [3:0]    mem_perm  [TABLE_DEPTH];
    logic [2:0]    mem_kind  [TABLE_DEPTH];

    logic [VA_BITS-1:0] r_base;
    t_state r_state, n_state;
    logic [IB:0] r_idx, n_idx;            // scan address
    logic r_rd_vld, n_rd_vld;             // read data belongs to r_rd_idx
    logic [IB-1:0] r_rd_idx, n_rd_idx;
    logic [PB-1:0] r_rd_start;
    logic [CB-1:0] r_rd_count;
    logic [3:0]    r_rd_perm;
    logic [2:0]    r_rd_kind;

    // Request registers
    logic [2:0] r_op, n_op, r_kind, n_kind;
    logic [3:0] r_perm, n_perm;
    logic r_fw, n_fw, r_misal, n_misal;
    logic [PB-1:0] r_spage, n_spage;
    logic [CB-1:0] r_pages, n_pages;     // rounded length, at least one page for map

    // Scan results
    logic r_hit, n_hit, r_ovl, n_ovl, r_free, n_free;
    logic [IB-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [PB-1:0] r_h_start, n_h_start;
    logic [CB-1:0] r_h_count, n_h_count;
    logic [3:0] r_h_perm, n_h_perm;
    logic [2:0] r_h_kind, n_h_kind;
    logic [CB:0] r_best, n_best;          // best end page

    // Write-back request
    logic r_we, n_we;
    logic [IB-1:0] r_widx, n_widx;
    logic [PB-1:0] r_wstart, n_wstart;
    logic [CB-1:0] r_wcount, n_wcount;
    logic [3:0] r_wperm, n_wperm;
    logic [2:0] r_wkind, n_wkind;

    logic [ODF-1:0] r_res, n_res;
    logic [CB:0] rd_end;
    logic [CB:0] req_end;
    logic [CB:0] len_pg;
    logic [2:0] st;
    logic [VA_BITS-1:0] f_start, f_size, rel_start, space;
    logic [3:0] f_perm;
    logic [2:0] f_type;
    logic wb, cf;
    logic [CB-1:0] rel_pages;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= VA_BITS'(MappingBaseReset);
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Table memory: registered read, single write
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem_start[r_widx] <= r_wstart;
            mem_count[r_widx] <= r_wcount;
            mem_perm[r_widx]  <= r_wperm;
            mem_kind[r_widx]  <= r_wkind;
        end
        r_rd_start <= mem_start[r_idx[IB-1:0]];
        r_rd_count <= mem_count[r_idx[IB-1:0]];
        r_rd_perm  <= mem_perm[r_idx[IB-1:0]];
        r_rd_kind  <= mem_kind[r_idx[IB-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_we     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= n_rd_vld;
            r_we     <= n_we;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_rd_idx <= n_rd_idx;
        r_op <= n_op; r_kind <= n_kind; r_perm <= n_perm; r_fw <= n_fw;
        r_misal <= n_misal; r_spage <= n_spage; r_pages <= n_pages;
        r_hit <= n_hit; r_ovl <= n_ovl; r_free <= n_free;
        r_hit_idx <= n_hit_idx; r_free_idx <= n_free_idx;
        r_h_start <= n_h_start; r_h_count <= n_h_count;
        r_h_perm <= n_h_perm; r_h_kind <= n_h_kind; r_best <= n_best;
        r_widx <= n_widx; r_wstart <= n_wstart; r_wcount <= n_wcount;
        r_wperm <= n_wperm; r_wkind <= n_wkind;
        r_res <= n_res;
    end

    // Shared compare unit operands
    assign rd_end   = {1'b0, r_rd_count} + (CB+1)'(r_rd_start);
    assign req_end  = {1'b0, r_pages} + (CB+1)'(r_spage);
    assign len_pg   = (CB+1)'(({1'b0, in_len} + (VA_BITS+1)'((1 << PAGE_SHIFT) - 1))
                      >> PAGE_SHIFT);

    // Sequencer
    always_comb begin
        n_state = r_state; n_valid = r_valid; n_idx = r_idx;
        n_rd_vld = 1'b0; n_rd_idx = r_idx[IB-1:0];
        n_op = r_op; n_kind = r_kind; n_perm = r_perm; n_fw = r_fw;
        n_misal = r_misal; n_spage = r_spage; n_pages = r_pages;
        n_hit = r_hit; n_ovl = r_ovl; n_free = r_free;
        n_hit_idx = r_hit_idx; n_free_idx = r_free_idx;
        n_h_start = r_h_start; n_h_count = r_h_count;
        n_h_perm = r_h_perm; n_h_kind = r_h_kind; n_best = r_best;
        n_we = 1'b0; n_widx = r_widx; n_wstart = r_wstart; n_wcount = r_wcount;
        n_wperm = r_wperm; n_wkind = r_wkind; n_res = r_res;
        st = ST_OK; f_start = '0; f_size = '0; f_perm = '0; f_type = '0;
        wb = 1'b0; cf = 1'b0; rel_start = '0; rel_pages = '0; space = '0;
        o_s_tready = (r_state == S_IDLE);
        o_m_tvalid = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op = in_op;
                    n_kind = (in_kind > KindAnon) ? KindAnon : in_kind;
                    n_perm = in_perm; n_fw = in_fw;
                    n_misal = |in_addr[PAGE_SHIFT-1:0];
                    n_spage = in_addr[VA_BITS-1:PAGE_SHIFT];
                    // a map covers at least one page
                    n_pages = (in_op == OP_MAP && len_pg == '0) ? CB'(1)
                                                               : len_pg[CB-1:0];
                    n_hit = 1'b0; n_ovl = 1'b0; n_free = 1'b0;
                    n_hit_idx = '0; n_free_idx = '0;
                    n_best = (CB+1)'(r_base >> PAGE_SHIFT);
                    n_idx = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue the next read, then judge the entry read last cycle
                if (r_idx <= LastIdx) begin
                    n_rd_vld = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_valid[r_rd_idx]) begin
                        if (!r_hit && ({1'b0, r_spage} >= (CB)'(r_rd_start))
                            && ((CB+1)'(r_spage) < rd_end)) begin
                            n_hit = 1'b1; n_hit_idx = r_rd_idx;
                            n_h_start = r_rd_start; n_h_count = r_rd_count;
                            n_h_perm = r_rd_perm; n_h_kind = r_rd_kind;
                        end
                        if (((CB+1)'(r_spage) < rd_end)
                            && ((CB+1)'(r_rd_start) < req_end))
                            n_ovl = 1'b1;
                        if (r_rd_kind != KindStack && rd_end > r_best)
                            n_best = rd_end;
                    end else if (!r_free) begin
                        n_free = 1'b1; n_free_idx = r_rd_idx;
                    end
                end
                if (!r_rd_vld && r_idx > LastIdx)
                    n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_OUT;
                case (r_op)
                    OP_MAP: begin
                        if (r_kind == KindFile && !r_fw && r_perm[PermWrite]
                            && r_perm[PermShared]) st = ST_FILE_RO;
                        else if (!r_free) st = ST_FULL;
                        else if (r_misal) st = ST_MISALIGN;
                        else if (req_end >= (CB+1)'(1 << PB)) st = ST_TOOLONG;
                        else if (r_ovl) st = ST_OVERLAP;
                        else begin
                            n_we = 1'b1; n_widx = r_free_idx;
                            n_wstart = r_spage; n_wcount = r_pages;
                            n_wperm = r_perm; n_wkind = r_kind;
                            n_valid[r_free_idx] = 1'b1;
                            f_start = VA_BITS'({r_spage, PAGE_SHIFT'(0)});
                            f_size = VA_BITS'({r_pages, PAGE_SHIFT'(0)});
                            f_perm = r_perm; f_type = r_kind;
                        end
                    end
                    OP_UNMAP, OP_LOOKUP: begin
                        if (!r_hit) st = ST_NOTFOUND;
                        else begin
                            f_start = VA_BITS'({r_h_start, PAGE_SHIFT'(0)});
                            f_size = VA_BITS'({r_h_count, PAGE_SHIFT'(0)});
                            f_perm = r_h_perm; f_type = r_h_kind;
                            if (r_op == OP_UNMAP) begin
                                if (r_misal || r_h_start != r_spage) st = ST_NOTSTART;
                                else if (r_pages > r_h_count) st = ST_TOOLONG;
                                else begin
                                    wb = r_h_kind == KindFile && r_h_perm[PermWrite]
                                         && r_h_perm[PermShared] && r_pages != '0;
                                    rel_start = f_start;
                                    rel_pages = r_pages;
                                    if (r_pages == r_h_count) begin
                                        n_valid[r_hit_idx] = 1'b0;
                                        f_size = '0;
                                        cf = (r_h_kind == KindFile);
                                    end else begin
                                        n_we = 1'b1; n_widx = r_hit_idx;
                                        n_wstart = r_h_start + PB'(r_pages);
                                        n_wcount = r_h_count - r_pages;
                                        n_wperm = r_h_perm; n_wkind = r_h_kind;
                                        f_start = VA_BITS'({n_wstart, PAGE_SHIFT'(0)});
                                        f_size = VA_BITS'({n_wcount, PAGE_SHIFT'(0)});
                                    end
                                end
                            end
                        end
                    end
                    OP_SPACE: begin
                        if (r_best == (CB+1)'(r_base >> PAGE_SHIFT)
                            || {r_best, PAGE_SHIFT'(0)} <= (CB+1+PAGE_SHIFT)'(r_base))
                            space = r_base;
                        else
                            space = VA_BITS'({r_best, PAGE_SHIFT'(0)});
                    end
                    OP_CLEAR: n_valid = '0;
                    default: ;
                endcase
                n_res = {space, rel_pages, rel_start, cf, wb, f_type, f_perm,
                         f_size, f_start, st};
            end
            S_WRITE: n_state = S_OUT;
            S_OUT: begin
                if (i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tdata = ODW'(r_res);

    logic unused_ok;
    assign unused_ok = ^{i_s_tdata[IDW-1:IDF], len_pg[CB]};

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_op == OP_CLEAR) |=> r_valid == '0)
        else $error("clear failed");
`endif
endmodule
`default_nettype wire
